[src/assert_macros.svh]
// Assertion macros for the checker file of the work/break timer.
// No dependencies; include by bare file name inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define ASSERT_IMP(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("timer check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define ASSERT_NXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("timer check failed");

`endif

[src/wbct_pkg.sv]
// Package of the work/break cycle timer: codes, widths, reset values, word layout.
// No dependencies; used by the top level and by its checker.
`timescale 1ns / 1ps

package wbct_pkg;

   localparam int SPAN_W     = 16;
   localparam int EVERY_W    = 7;
   localparam int LIMIT_W    = 7;
   localparam int LOOP_W     = 16;
   localparam int ELAPSED_W  = 17;
   localparam int GAP_W      = 8;
   localparam int OP_W       = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int RSP_DATA_W = 40;

   localparam logic [GAP_W-1:0]     GAP_LIMIT   = 8'd60;
   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 17'h1FFFF;

   localparam logic [SPAN_W-1:0]  WORK_SPAN_RST   = 16'd1500;
   localparam logic [SPAN_W-1:0]  SHORT_SPAN_RST  = 16'd300;
   localparam logic [SPAN_W-1:0]  LONG_SPAN_RST   = 16'd600;
   localparam logic [EVERY_W-1:0] EVERY_RST       = 7'd4;
   localparam logic [LIMIT_W-1:0] LOOP_LIMIT_RST  = 7'd4;

   typedef enum logic [OP_W-1:0] {
      OP_TICK  = 3'd0,
      OP_START = 3'd1,
      OP_PAUSE = 3'd2,
      OP_STOP  = 3'd3,
      OP_SKIP  = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      MODE_STOPPED = 2'd0,
      MODE_RUNNING = 2'd1,
      MODE_PAUSED  = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      PH_WORK  = 2'd0,
      PH_SHORT = 2'd1,
      PH_LONG  = 2'd2
   } phase_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_WORK_SPAN   = 3'd0,
      REG_SHORT_SPAN  = 3'd1,
      REG_LONG_SPAN   = 3'd2,
      REG_LONG_EVERY  = 3'd3,
      REG_LONG_ENABLE = 3'd4,
      REG_REPEAT      = 3'd5,
      REG_LOOP_LIMIT  = 3'd6,
      REG_CHIME       = 3'd7
   } reg_idx_type;

   // Result word, lowest field last.
   typedef struct packed {
      logic [2:0]        pad;
      logic [LOOP_W-1:0] loops_done;
      logic              chime;
      logic [SPAN_W-1:0] remaining_seconds;
      logic [1:0]        phase;
      logic [1:0]        run_state;
   } rsp_word_type;

endpackage

[src/work_break_cycle_timer.sv]
// Top level of the work/break cycle timer: command decode, phase state and result register.
// Depends on wbct_pkg.
`timescale 1ns / 1ps

// Usage
// The request channel carries one command word per handshake: the operation code
// travels on req_tuser and the elapsed seconds of a tick on req_tdata. Every
// accepted word produces exactly one result word on the rsp_ channel, holding the
// run state, the phase, the seconds left in the phase, a chime flag and the loop count.
// The result of a word accepted at one edge is registered and valid right after it.
// Throughput is one word per cycle while results are taken; the whole state update is
// a handful of adds and compares on the state registers, finished in the accepting cycle.
// The result register frees up in the same cycle its word is taken, so a new
// request is taken whenever the register is empty or rsp_tready is high. When the
// receiver stalls with a result pending, req_tready drops and the state holds.
// Timing registers are written through the csr_ port at any edge with csr_we high;
// they should only change while no command is in flight.
// A synchronous reset stops the timer, clears all loop bookkeeping, restores the
// register defaults and empties the result register.
module work_break_cycle_timer (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [wbct_pkg::GAP_W-1:0]        req_tdata,   // [7:0] elapsed_seconds
   input  logic [wbct_pkg::OP_W-1:0]         req_tuser,   // [2:0] operation
   // Result channel.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [1:0] run_state, [3:2] phase, [19:4] remaining_seconds, [20] chime,
   // [36:21] loops_done, [39:37] zero
   output logic [wbct_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // Configuration write port.
   input  logic                              csr_we,
   input  logic [wbct_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [wbct_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import wbct_pkg::*;

   // Configuration registers.
   logic [SPAN_W-1:0]  work_span_ff, short_span_ff, long_span_ff;
   logic [EVERY_W-1:0] every_ff;
   logic [LIMIT_W-1:0] limit_ff;
   logic               long_en_ff, repeat_ff, chime_en_ff;

   // Timer state.
   mode_type              mode_ff, mode_in;
   phase_type             phase_ff, phase_in;
   logic [ELAPSED_W-1:0]  elapsed_ff, elapsed_in;
   logic [SPAN_W-1:0]     target_ff, target_in;
   logic [EVERY_W-1:0]    latched_ff, latched_in;
   logic [LOOP_W-1:0]     lba_ff, lba_in;
   logic [LOOP_W-1:0]     loop_ff, loop_in;

   // Result register.
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   logic                 accept;
   op_type               op;
   logic [ELAPSED_W:0]   elapsed_sum;
   logic [ELAPSED_W-1:0] elapsed_sat;
   logic                 every_diff, take_long, break_stops, chime_in;
   logic [EVERY_W-1:0]   latched_work;
   logic [LOOP_W-1:0]    loop_plus1, lba_pre, lba_work;
   logic [SPAN_W-1:0]    target_work;
   phase_type            phase_work;

   // A result is taken out in the same cycle a new one may be written.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign op         = op_type'(req_tuser);

   // Saturating accumulation of the tick gap.
   assign elapsed_sum = {1'b0, elapsed_ff} + {{(ELAPSED_W+1-GAP_W){1'b0}}, req_tdata};
   assign elapsed_sat = elapsed_sum[ELAPSED_W] ? ELAPSED_MAX : elapsed_sum[ELAPSED_W-1:0];

   // Outcome of a work phase ending. A new long_break_every re-arms the long break
   // target relative to the current loop count.
   assign loop_plus1   = loop_ff + 1'b1;
   assign every_diff   = latched_ff != every_ff;
   assign lba_pre      = every_diff ? loop_ff + {{(LOOP_W-EVERY_W){1'b0}}, every_ff} : lba_ff;
   assign take_long    = long_en_ff && (loop_plus1 == lba_pre);
   assign latched_work = !long_en_ff ? '0 : (every_diff ? every_ff : latched_ff);
   assign lba_work     = !long_en_ff ? '0 :
                         take_long ? loop_plus1 + {{(LOOP_W-EVERY_W){1'b0}}, latched_work}
                                   : lba_pre;
   assign target_work  = take_long ? long_span_ff : short_span_ff;
   assign phase_work   = take_long ? PH_LONG : PH_SHORT;

   // A break ending completes a loop; the timer stops without repeat or at the limit.
   assign break_stops = !repeat_ff ||
                        ((limit_ff != '0) &&
                         (loop_plus1 >= {{(LOOP_W-LIMIT_W){1'b0}}, limit_ff}));

   always_comb begin
      mode_in    = mode_ff;
      phase_in   = phase_ff;
      elapsed_in = elapsed_ff;
      target_in  = target_ff;
      latched_in = latched_ff;
      lba_in     = lba_ff;
      loop_in    = loop_ff;
      chime_in   = 1'b0;

      case (op)
         OP_TICK: begin
            if (mode_ff == MODE_RUNNING) begin
               if (req_tdata > GAP_LIMIT) begin
                  // A long gap means the host lost track of time; stop everything.
                  mode_in    = MODE_STOPPED;
                  phase_in   = PH_WORK;
                  elapsed_in = '0;
                  target_in  = '0;
                  latched_in = '0;
                  lba_in     = '0;
                  loop_in    = '0;
               end else if (elapsed_sat >= {1'b0, target_ff}) begin
                  chime_in   = chime_en_ff;
                  elapsed_in = '0;
                  if (phase_ff == PH_WORK) begin
                     phase_in   = phase_work;
                     target_in  = target_work;
                     latched_in = latched_work;
                     lba_in     = lba_work;
                  end else if (break_stops) begin
                     mode_in    = MODE_STOPPED;
                     phase_in   = PH_WORK;
                     target_in  = '0;
                     latched_in = '0;
                     lba_in     = '0;
                     loop_in    = '0;
                  end else begin
                     phase_in  = PH_WORK;
                     target_in = work_span_ff;
                     loop_in   = loop_plus1;
                  end
               end else begin
                  elapsed_in = elapsed_sat;
               end
            end
         end
         OP_START: begin
            mode_in = MODE_RUNNING;
            if (target_ff == '0) begin
               target_in = work_span_ff;
            end
         end
         OP_PAUSE: begin
            mode_in = MODE_PAUSED;
         end
         OP_STOP: begin
            mode_in    = MODE_STOPPED;
            phase_in   = PH_WORK;
            elapsed_in = '0;
            target_in  = '0;
            latched_in = '0;
            lba_in     = '0;
            loop_in    = '0;
         end
         OP_SKIP: begin
            if (mode_ff != MODE_STOPPED) begin
               elapsed_in = '0;
               if (phase_ff == PH_WORK) begin
                  phase_in   = phase_work;
                  target_in  = target_work;
                  latched_in = latched_work;
                  lba_in     = lba_work;
               end else if (break_stops) begin
                  mode_in    = MODE_STOPPED;
                  phase_in   = PH_WORK;
                  target_in  = '0;
                  latched_in = '0;
                  lba_in     = '0;
                  loop_in    = '0;
               end else begin
                  phase_in  = PH_WORK;
                  target_in = work_span_ff;
                  loop_in   = loop_plus1;
               end
               // Skipping out of pause resumes the timer unless the skip stopped it.
               if ((mode_in != MODE_STOPPED) && (mode_ff == MODE_PAUSED)) begin
                  mode_in = MODE_RUNNING;
                  if (target_in == '0) begin
                     target_in = work_span_ff;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Result word built from the updated state.
   always_comb begin
      rsp_word_in            = '0;
      rsp_word_in.run_state  = mode_in;
      rsp_word_in.phase      = phase_in;
      rsp_word_in.chime      = chime_in;
      rsp_word_in.loops_done = loop_in;
      if ((mode_in == MODE_RUNNING) && ({1'b0, target_in} >= elapsed_in)) begin
         rsp_word_in.remaining_seconds = target_in - elapsed_in[SPAN_W-1:0];
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         work_span_ff  <= WORK_SPAN_RST;
         short_span_ff <= SHORT_SPAN_RST;
         long_span_ff  <= LONG_SPAN_RST;
         every_ff      <= EVERY_RST;
         long_en_ff    <= 1'b0;
         repeat_ff     <= 1'b0;
         limit_ff      <= LOOP_LIMIT_RST;
         chime_en_ff   <= 1'b1;
      end else if (csr_we) begin
         case (reg_idx_type'(csr_index))
            REG_WORK_SPAN:   work_span_ff  <= csr_wdata;
            REG_SHORT_SPAN:  short_span_ff <= csr_wdata;
            REG_LONG_SPAN:   long_span_ff  <= csr_wdata;
            REG_LONG_EVERY:  every_ff      <= csr_wdata[EVERY_W-1:0];
            REG_LONG_ENABLE: long_en_ff    <= csr_wdata[0];
            REG_REPEAT:      repeat_ff     <= csr_wdata[0];
            REG_LOOP_LIMIT:  limit_ff      <= csr_wdata[LIMIT_W-1:0];
            REG_CHIME:       chime_en_ff   <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_STOPPED;
         phase_ff     <= PH_WORK;
         elapsed_ff   <= '0;
         target_ff    <= '0;
         latched_ff   <= '0;
         lba_ff       <= '0;
         loop_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            mode_ff    <= mode_in;
            phase_ff   <= phase_in;
            elapsed_ff <= elapsed_in;
            target_ff  <= target_in;
            latched_ff <= latched_in;
            lba_ff     <= lba_in;
            loop_ff    <= loop_in;
         end
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_word_ff;

endmodule

[src/wbct_checker.sv]
// Port-level checker for the work/break cycle timer, bound to the top level.
// Depends on wbct_pkg and assert_macros.svh.
`timescale 1ns / 1ps

module wbct_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [wbct_pkg::GAP_W-1:0]        req_tdata,
   input logic [wbct_pkg::OP_W-1:0]         req_tuser,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [wbct_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic                              csr_we,
   input logic [wbct_pkg::CSR_IDX_W-1:0]    csr_index,
   input logic [wbct_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import wbct_pkg::*;
   `include "assert_macros.svh"

   rsp_word_type word;
   logic         stopped_ok, idle_zero, req_accept, rsp_stall;

   assign word       = rsp_tdata;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_stall  = rsp_tvalid && !rsp_tready;
   // Stopping clears the whole state, so a stopped result shows a fresh timer.
   assign stopped_ok = (word.phase == PH_WORK) && (word.loops_done == '0);
   assign idle_zero  = word.remaining_seconds == '0;

   // Every accepted command yields a result in the next cycle.
   `ASSERT_NXT(a_one_cycle_result, clock, reset, req_accept, rsp_tvalid)
   // A stalled result holds its word.
   `ASSERT_NXT(a_stall_holds, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))
   // Reset empties the result register.
   `ASSERT_NXT(a_reset_empties, clock, 1'b0, reset, !rsp_tvalid)
   `ASSERT_IMP(a_stopped_fresh, clock, reset,
      rsp_tvalid && (word.run_state == MODE_STOPPED), stopped_ok && idle_zero)
   `ASSERT_IMP(a_idle_no_time, clock, reset,
      rsp_tvalid && (word.run_state == MODE_PAUSED), idle_zero)

   logic unused_ok;
   assign unused_ok = ^{req_tdata, req_tuser, csr_we, csr_index, csr_wdata};

endmodule

bind work_break_cycle_timer wbct_checker u_wbct_checker (.*);

[tb/sv/wbct_tb_pkg.sv]
// Scoreboard of the work/break cycle timer bench: a cycle-free model of the timer state
// and the queue of result words still due. Depends on wbct_pkg.
`timescale 1ns / 1ps

package wbct_tb_pkg;
   import wbct_pkg::*;

   class timer_scoreboard;
      // Register copies, masked to their widths.
      logic [SPAN_W-1:0]  work_span, short_span, long_span;
      logic [EVERY_W-1:0] every;
      logic [LIMIT_W-1:0] limit;
      logic               long_en, repeat_en, chime_en;

      // Timer state.
      mode_type              mode;
      phase_type             ph;
      logic [ELAPSED_W-1:0]  elapsed;
      logic [SPAN_W-1:0]     target;
      logic [EVERY_W-1:0]    latched;
      logic [LOOP_W-1:0]     long_at;
      logic [LOOP_W-1:0]     loops;

      rsp_word_type due_words[$];
      int errors, checked, chimes, long_breaks, wraps;

      function new();
         work_span  = WORK_SPAN_RST;
         short_span = SHORT_SPAN_RST;
         long_span  = LONG_SPAN_RST;
         every      = EVERY_RST;
         limit      = LOOP_LIMIT_RST;
         long_en    = 1'b0;
         repeat_en  = 1'b0;
         chime_en   = 1'b1;
         clear_timer();
         errors      = 0;
         checked     = 0;
         chimes      = 0;
         long_breaks = 0;
         wraps       = 0;
      endfunction

      function void note_register(reg_idx_type idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            REG_WORK_SPAN:   work_span  = val[SPAN_W-1:0];
            REG_SHORT_SPAN:  short_span = val[SPAN_W-1:0];
            REG_LONG_SPAN:   long_span  = val[SPAN_W-1:0];
            REG_LONG_EVERY:  every      = val[EVERY_W-1:0];
            REG_LONG_ENABLE: long_en    = val[0];
            REG_REPEAT:      repeat_en  = val[0];
            REG_LOOP_LIMIT:  limit      = val[LIMIT_W-1:0];
            REG_CHIME:       chime_en   = val[0];
            default: ;
         endcase
      endfunction

      function void clear_timer();
         mode    = MODE_STOPPED;
         ph      = PH_WORK;
         elapsed = '0;
         target  = '0;
         latched = '0;
         long_at = '0;
         loops   = '0;
      endfunction

      function void start_timer();
         mode = MODE_RUNNING;
         if (target == 0) target = work_span;
      endfunction

      // End of a work phase: choose the short or the long break.
      function void finish_work();
         if (long_en) begin
            if (latched != every) begin
               latched = every;
               long_at = loops + LOOP_W'(every);
            end
            if (loops + 16'd1 == long_at) begin
               target  = long_span;
               ph      = PH_LONG;
               long_at = loops + 16'd1 + LOOP_W'(latched);
               long_breaks++;
            end else begin
               target = short_span;
               ph     = PH_SHORT;
            end
         end else begin
            latched = '0;
            long_at = '0;
            target  = short_span;
            ph      = PH_SHORT;
         end
      endfunction

      // End of a break: one more loop; returns 0 when the timer stops.
      function bit finish_break();
         target = work_span;
         ph     = PH_WORK;
         loops  = loops + 16'd1;
         if (loops == 0) wraps++;
         if (!repeat_en || (limit != 0 && loops >= LOOP_W'(limit))) begin
            clear_timer();
            return 1'b0;
         end
         return 1'b1;
      endfunction

      // Advance the timer by one accepted command word and queue the result it causes.
      function void predict_command(logic [OP_W-1:0] op, logic [GAP_W-1:0] gap);
         rsp_word_type w;
         logic [ELAPSED_W:0] sum;
         logic chime;
         bit go;
         chime = 1'b0;
         case (op)
            OP_TICK: begin
               if (mode == MODE_RUNNING) begin
                  if (gap > GAP_LIMIT) begin
                     clear_timer();
                  end else begin
                     sum = (ELAPSED_W+1)'(elapsed) + (ELAPSED_W+1)'(gap);
                     elapsed = (sum > (ELAPSED_W+1)'(ELAPSED_MAX)) ? ELAPSED_MAX
                                                                  : sum[ELAPSED_W-1:0];
                     if (elapsed >= ELAPSED_W'(target)) begin
                        elapsed = '0;
                        chime = chime_en;
                        if (chime) chimes++;
                        if (ph == PH_WORK) finish_work();
                        else void'(finish_break());
                     end
                  end
               end
            end
            OP_START: start_timer();
            OP_PAUSE: mode = MODE_PAUSED;
            OP_STOP:  clear_timer();
            OP_SKIP: begin
               if (mode != MODE_STOPPED) begin
                  go = 1'b1;
                  elapsed = '0;
                  if (ph == PH_WORK) finish_work();
                  else go = finish_break();
                  if (go && mode == MODE_PAUSED) start_timer();
               end
            end
            default: ;
         endcase
         w.pad       = '0;
         w.run_state = mode;
         w.phase     = ph;
         if (mode == MODE_RUNNING && ELAPSED_W'(target) >= elapsed)
            w.remaining_seconds = target - elapsed[SPAN_W-1:0];
         else
            w.remaining_seconds = '0;
         w.chime      = chime;
         w.loops_done = loops;
         due_words.push_back(w);
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      // Compare one accepted result word with the oldest one due.
      function void check_word(logic [RSP_DATA_W-1:0] data);
         rsp_word_type got, want;
         got = data;
         if (due_words.size() == 0) begin
            $error("result word %h arrived with none due", data);
            errors++;
            return;
         end
         want = due_words.pop_front();
         checked++;
         compare_field("run_state", 16'(want.run_state), 16'(got.run_state));
         compare_field("phase", 16'(want.phase), 16'(got.phase));
         compare_field("remaining_seconds", want.remaining_seconds, got.remaining_seconds);
         compare_field("chime", 16'(want.chime), 16'(got.chime));
         compare_field("loops_done", want.loops_done, got.loops_done);
         compare_field("pad", 16'(want.pad), 16'(got.pad));
      endfunction
   endclass

endpackage

[tb/sv/tb_work_break_cycle_timer.sv]
// Top of the work/break cycle timer bench: clock, reset, stimulus and result checking.
// Depends on wbct_pkg, wbct_tb_pkg and the work_break_cycle_timer RTL.
`timescale 1ns / 1ps

module tb_work_break_cycle_timer;
   import wbct_pkg::*;
   import wbct_tb_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [GAP_W-1:0]      req_tdata;
   logic [OP_W-1:0]       req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   timer_scoreboard board;

   // When quiet is set, neither side idles between words.
   bit quiet;
   // A nonzero value makes the receiver hold rsp_tready low that many cycles once.
   int hold_request;
   int words_sent;
   int settings_done;

   work_break_cycle_timer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // The slowest correct run sends about 1300 words with the longest idling on
   // both sides, plus one long receiver hold.
   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic int idle_cycles();
      return quiet ? 0 : $urandom_range(0, 10);
   endfunction

   // Offer one command word and return at the edge where it is taken. All tasks
   // start and end right after a rising edge, so every drive is a single
   // nonblocking assignment in that time step and every sample sees the values
   // from before the edge.
   task automatic send_word(input logic [OP_W-1:0] op, input logic [GAP_W-1:0] gap,
                            input int idle);
      if (idle > 0) begin
         req_tvalid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= gap;
      do @(posedge clock); while (!req_tready);
      board.predict_command(op, gap);
      words_sent++;
   endtask

   task automatic send_plain(input logic [OP_W-1:0] op, input logic [GAP_W-1:0] gap);
      send_word(op, gap, idle_cycles());
   endtask

   // The write enable stays high across back-to-back writes; program_timer
   // lowers it after the last one.
   task automatic write_reg(input reg_idx_type idx, input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      board.note_register(idx, val);
   endtask

   task automatic program_timer(input logic [15:0] ws, input logic [15:0] ss,
                                input logic [15:0] ls, input logic [15:0] ev,
                                input logic [15:0] le, input logic [15:0] re,
                                input logic [15:0] ll, input logic [15:0] ce);
      write_reg(REG_WORK_SPAN, ws);
      write_reg(REG_SHORT_SPAN, ss);
      write_reg(REG_LONG_SPAN, ls);
      write_reg(REG_LONG_EVERY, ev);
      write_reg(REG_LONG_ENABLE, le);
      write_reg(REG_REPEAT, re);
      write_reg(REG_LOOP_LIMIT, ll);
      write_reg(REG_CHIME, ce);
      csr_we <= 1'b0;
      settings_done++;
   endtask

   // Stop offering and wait until every due result word has been taken and the
   // block is left idle.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.due_words.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Mostly ticks of a legal gap, with a start offered often whenever the timer is
   // not running so that the phases keep moving. Words the block ignores are sent
   // but not counted. With no_stop set, no stop command or long gap is sent, which keeps the
   // loop counter climbing.
   task automatic run_random(input int count, input bit no_stop);
      int acted;
      int r;
      logic [OP_W-1:0]  op;
      logic [GAP_W-1:0] gap;
      acted = 0;
      while (acted < count) begin
         if (!no_stop && $urandom_range(0, 15) == 0)
            gap = GAP_W'($urandom_range(61, 255));
         else
            gap = GAP_W'($urandom_range(0, 60));
         r = $urandom_range(0, 99);
         if (board.mode != MODE_RUNNING && r < 50) begin
            op = OP_START;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 60)       op = OP_TICK;
            else if (r < 70)  op = OP_START;
            else if (r < 78)  op = OP_PAUSE;
            else if (r < 82)  op = no_stop ? OP_SKIP : OP_STOP;
            else if (r < 97)  op = OP_SKIP;
            else              op = OP_W'($urandom_range(5, 7));
         end
         if (!((op == OP_TICK && board.mode != MODE_RUNNING) || op > OP_SKIP ||
               (op == OP_SKIP && board.mode == MODE_STOPPED)))
            acted++;
         send_plain(op, gap);
      end
   endtask

   function automatic logic [15:0] draw_span();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return 16'($urandom);
      if (r == 1) return 16'($urandom_range(0, 59));
      return 16'($urandom_range(60, 180));
   endfunction

   // Receiver: stalls a random number of cycles before each word, and once holds
   // off for a long stretch when asked, then takes and checks one result word.
   initial begin
      int stall;
      rsp_tready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = idle_cycles();
         if (hold_request > 0) begin
            stall = hold_request;
            hold_request = 0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         board.check_word(rsp_tdata);
      end
   end

   initial begin
      logic [15:0] noise;
      logic [15:0] ws, ss, ls, ev, le, re, ll, ce;
      board = new();
      quiet = 1'b0;
      hold_request = 0;
      words_sent = 0;
      settings_done = 0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset settings: ticks while stopped and paused are
      // ignored, a gap over sixty stops the timer, pause works from stopped, a skip
      // starts a paused timer, and a break end without repeat stops it.
      send_plain(OP_TICK, 8'd10);
      send_plain(OP_START, 8'd0);
      send_plain(OP_TICK, 8'd60);
      send_plain(OP_PAUSE, 8'd0);
      send_plain(OP_TICK, 8'd5);
      send_plain(OP_START, 8'd0);
      send_plain(OP_TICK, 8'd61);
      send_plain(OP_PAUSE, 8'd0);
      send_plain(OP_SKIP, 8'd0);
      send_plain(OP_SKIP, 8'd0);
      send_plain(3'd7, 8'd33);
      send_plain(OP_SKIP, 8'd0);
      drain();

      // Shortest legal spans with a long break every second work phase: chimes on
      // timed ends, a long break, a skip out of a paused long break, then a
      // maximal gap and the codes beyond skip.
      program_timer(16'd60, 16'd60, 16'd60, 16'd2, 16'd1, 16'd1, 16'd0, 16'd1);
      send_plain(OP_START, 8'd0);
      send_plain(OP_TICK, 8'd0);
      send_plain(OP_TICK, 8'd60);
      send_plain(OP_TICK, 8'd60);
      send_plain(OP_TICK, 8'd60);
      send_plain(OP_PAUSE, 8'd0);
      send_plain(OP_SKIP, 8'd0);
      send_plain(3'd5, 8'd0);
      send_plain(OP_TICK, 8'd255);
      send_plain(OP_START, 8'd0);
      send_plain(OP_STOP, 8'd0);
      send_plain(3'd6, 8'd200);
      drain();

      // Random part: thirteen settings of about eighty words each, the
      // extremes first. The timer state carries over from one setting to the next,
      // so a changed long-break interval re-arms the long-break target.
      for (int p = 0; p < 13; p++) begin
         noise = 16'($urandom);
         case (p)
            0: program_timer(16'd60, 16'd60, 16'd60, 16'd1, 16'd1, 16'd1, 16'd1, 16'd0);
            1: program_timer(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd100, 16'd1, 16'd1,
                             16'd100, 16'd1);
            // Values outside the legal ranges, with the upper bits of the narrow
            // registers set so that the masking shows.
            2: program_timer(16'd0, 16'd1, 16'd59, 16'hFF80, 16'hFFFF, 16'hFFFF,
                             16'hFFFF, 16'hFFFE);
            default: begin
               ws = draw_span();
               ss = draw_span();
               ls = draw_span();
               ev = {noise[15:7], 7'($urandom_range(0, 4) == 0 ? $urandom_range(0, 127)
                                                             : $urandom_range(1, 5))};
               le = {noise[15:1], 1'($urandom_range(0, 3) != 0)};
               re = {noise[15:1], 1'($urandom_range(0, 3) != 0)};
               ll = {noise[15:7], 7'($urandom_range(0, 2) == 0 ? 0
                                   : ($urandom_range(0, 5) == 0 ? $urandom_range(1, 127)
                                                                : $urandom_range(1, 8)))};
               ce = {noise[15:1], 1'($urandom_range(0, 9) < 7)};
               program_timer(ws, ss, ls, ev, le, re, ll, ce);
            end
         endcase

         // One setting runs with a long receiver hold while the sender keeps
         // offering back to back, so the result register fills and the input
         // stalls; the two after it run with no idling on either side.
         quiet = (p >= 4 && p <= 6);
         if (p == 4) hold_request = 300;
         run_random(80, 1'b0);
         drain();
      end

      // Random traffic without stops under the shortest spans with repeat on and
      // no loop limit, so the loop counter and the long-break target keep climbing.
      quiet = 1'b0;
      program_timer(16'd60, 16'd60, 16'd60, 16'($urandom_range(1, 6)), 16'd1, 16'd1,
                    16'd0, 16'd1);
      run_random(60, 1'b1);
      drain();

      $display("Sent %0d command words under %0d register settings; %0d results checked.",
               words_sent, settings_done, board.checked);
      $display("Seen %0d chimes and %0d long breaks.",
               board.chimes, board.long_breaks);
      if (board.errors == 0 && board.due_words.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
